// ===== rtl/core/pvm_pkg.sv =====
// Shared widths, operation codes and constants of the PCM voice mixer.
`default_nettype none
package pvm_pkg;

    localparam int OP_W     = 3;
    localparam int IN_ADDR_W = 16;
    localparam int POS_W    = 17;
    localparam int SAMPLE_W = 8;
    localparam int VOL_W    = 8;
    localparam int FLAGS_W  = 4;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [SAMPLE_W-1:0] sample_t;

    localparam op_t OP_TICK       = 3'd0;
    localparam op_t OP_MUSIC_PLAY = 3'd1;
    localparam op_t OP_MUSIC_STOP = 3'd2;
    localparam op_t OP_FX_PLAY    = 3'd3;
    localparam op_t OP_FX_STOP    = 3'd4;
    localparam op_t OP_LOAD       = 3'd5;

    localparam sample_t SILENCE    = 8'd128;
    localparam sample_t SAMPLE_MAX = 8'd255;
    localparam logic [VOL_W-1:0] VOL_RESET = 8'd255;

endpackage
`default_nettype wire

// ===== rtl/core/pcm_voice_mixer.sv =====
// Top level of the PCM voice mixer: sample memory, voice memory and mixing sequencer.
//
// Requests enter on in_valid/in_stall and carry operation, address, length,
// loop_enable and sample_byte. Each request gives one result on
// out_valid/out_stall: sample_out (mixed sample on tick, 128 otherwise),
// music_playing and effects_active. The output gain is written through
// cfg_write/cfg_data. Play, stop and load requests go from the done state
// into the output register. A tick sweeps all voices through the voice memory
// one at a time: read, evaluate and accumulate for an active voice (no
// accumulate for one that ends on this tick), read only for an idle voice,
// then multiply, divide, finish and done to scale the sum and output it. The
// sweep goes voice by voice as each memory has a single read port. One request
// is worked on at a time; in_stall drops as a result enters the output register.
// A finished result waits there while the next request is taken.
// When the receiver stalls, the next result holds in its final step and
// in_stall stays high until the output register frees up.
// Reset idles all voices and sets the gain to 255; the sample memory
// holds unknown data until loaded, and the voice memory needs no clearing.
`default_nettype none
module pcm_voice_mixer #(
    parameter int SAMPLE_DEPTH  = 65536,
    parameter int EFFECT_VOICES = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [pvm_pkg::VOL_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic [pvm_pkg::OP_W-1:0]          operation,
    input  wire logic [pvm_pkg::IN_ADDR_W-1:0]     address,
    input  wire logic [pvm_pkg::POS_W-1:0]         length,
    input  wire logic                              loop_enable,
    input  wire logic [pvm_pkg::SAMPLE_W-1:0]      sample_byte,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [pvm_pkg::SAMPLE_W-1:0]      sample_out,
    output      logic                              music_playing,
    output      logic [pvm_pkg::FLAGS_W-1:0]       effects_active
);

    localparam int AW         = $clog2(SAMPLE_DEPTH);
    localparam int WRAP_W     = AW + 9;
    localparam int NUM_VOICES = EFFECT_VOICES + 1;
    localparam int VW         = $clog2(NUM_VOICES);
    localparam int SUM_W      = 8 + $clog2(NUM_VOICES);
    localparam int PROD_W     = SUM_W + 9;
    localparam int POS_W      = pvm_pkg::POS_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_VREAD = 4'd1;
    localparam logic [3:0] S_VEVAL = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    typedef struct packed {
        logic [AW-1:0]    base;
        logic [POS_W-1:0] len;
        logic [POS_W-1:0] pos;
        logic [AW-1:0]    cur;
        logic             looping;
    } voice_t;

    function automatic logic [AW-1:0] wrap_addr(input logic [pvm_pkg::IN_ADDR_W-1:0] a);
        logic [WRAP_W-1:0] v;
        logic [WRAP_W-1:0] d;
        v = WRAP_W'(a);
        for (int k = 7; k >= 0; k--) begin
            d = WRAP_W'(SAMPLE_DEPTH) << k;
            if (v >= d) begin
                v = v - d;
            end
        end
        return v[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
        return (a == AW'(SAMPLE_DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    // memories
    logic [pvm_pkg::SAMPLE_W-1:0] smem [SAMPLE_DEPTH];
    voice_t                       vmem [NUM_VOICES];

    logic [3:0]                   state_reg, state_next;
    logic [VW-1:0]                idx_reg, idx_next;
    logic [NUM_VOICES-1:0]        active_reg, active_next;
    logic [pvm_pkg::VOL_W-1:0]    volume_reg;
    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic signed [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]            mag_reg;
    logic [PROD_W:0]              qe_reg;
    logic                         neg_reg;
    logic [pvm_pkg::SAMPLE_W-1:0] res_sample_reg, res_sample_next;
    logic                         out_valid_reg;
    logic [pvm_pkg::SAMPLE_W-1:0] sample_out_reg;
    logic                         music_playing_reg;
    logic [pvm_pkg::FLAGS_W-1:0]  effects_active_reg;

    voice_t                       vrd_reg;
    logic [pvm_pkg::SAMPLE_W-1:0] srd_reg;

    logic                         accept;
    logic                         out_free;
    logic                         vwe;
    logic [VW-1:0]                vwaddr;
    voice_t                       vwdata;
    logic                         swe;
    logic [AW-1:0]                saddr;
    logic [AW-1:0]                start_wrapped;
    logic [VW-1:0]                slot;
    voice_t                       nrec;
    logic                         go;
    logic [AW-1:0]                fetch_addr;
    logic                         last_voice;
    logic                         cur_active;
    logic signed [SUM_W-1:0]      centered;
    logic [PROD_W-1:0]            mag;
    logic [PROD_W:0]              qe_calc;
    logic [PROD_W:0]              rem;
    logic [PROD_W:0]              quot;
    logic [NUM_VOICES+3:0]        flags_ext;

    assign accept        = in_valid && !in_stall;
    assign in_stall      = (state_reg != S_IDLE);
    assign out_free      = !out_valid_reg || !out_stall;
    assign start_wrapped = wrap_addr(address);
    assign last_voice    = (idx_reg == VW'(NUM_VOICES - 1));
    assign cur_active    = active_reg[idx_reg];
    assign centered      = SUM_W'(signed'({1'b0, srd_reg})) - SUM_W'(signed'(9'sd128));
    assign flags_ext     = {4'b0, active_reg};

    // first idle effect voice, voice 0 of the effects when all are busy
    always_comb
    begin
        slot = VW'(1);
        for (int i = EFFECT_VOICES - 1; i >= 0; i--) begin
            if (!active_reg[i + 1]) begin
                slot = VW'(i + 1);
            end
        end
    end

    // voice evaluation on a tick
    always_comb
    begin
        nrec       = vrd_reg;
        go         = 1'b1;
        fetch_addr = vrd_reg.cur;
        if (vrd_reg.looping && vrd_reg.len == '0) begin
            go = 1'b0;
        end else if (vrd_reg.pos >= vrd_reg.len) begin
            if (vrd_reg.looping) begin
                nrec.pos   = '0;
                fetch_addr = vrd_reg.base;
            end else begin
                go = 1'b0;
            end
        end
        if (go) begin
            nrec.pos = nrec.pos + POS_W'(1);
            nrec.cur = next_addr(fetch_addr);
        end
    end

    // scaling by volume / 255
    always_comb
    begin
        mag     = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        qe_calc = ((PROD_W+1)'(mag) + (PROD_W+1)'(mag >> 8) + (PROD_W+1)'(mag >> 16)) >> 8;
        rem     = (PROD_W+1)'(mag_reg) - ((qe_reg << 8) - qe_reg);
        quot    = qe_reg + ((rem >= (PROD_W+1)'(pvm_pkg::SAMPLE_MAX)) ? (PROD_W+1)'(1) : '0);
    end

    // memory port control
    always_comb
    begin
        vwe    = 1'b0;
        vwaddr = idx_reg;
        vwdata = nrec;
        swe    = 1'b0;
        saddr  = fetch_addr;
        if (accept) begin
            saddr = start_wrapped;
            unique case (operation)
                pvm_pkg::OP_MUSIC_PLAY:
                begin
                    vwe    = 1'b1;
                    vwaddr = '0;
                    vwdata = '{base: start_wrapped, len: length, pos: '0,
                               cur: start_wrapped, looping: loop_enable};
                end
                pvm_pkg::OP_FX_PLAY:
                begin
                    vwe    = 1'b1;
                    vwaddr = slot;
                    vwdata = '{base: start_wrapped, len: length, pos: '0,
                               cur: start_wrapped, looping: 1'b0};
                end
                pvm_pkg::OP_LOAD:
                begin
                    swe = 1'b1;
                end
                default:
                begin
                end
            endcase
        end else if (state_reg == S_VEVAL) begin
            vwe = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vwe) begin
            vmem[vwaddr] <= vwdata;
        end
        vrd_reg <= vmem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (swe) begin
            smem[saddr] <= sample_byte;
        end
        srd_reg <= smem[saddr];
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        active_next     = active_reg;
        sum_next        = sum_reg;
        res_sample_next = res_sample_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    res_sample_next = pvm_pkg::SILENCE;
                    idx_next        = '0;
                    sum_next        = '0;
                    state_next      = S_DONE;
                    unique case (operation)
                        pvm_pkg::OP_TICK:       state_next = S_VREAD;
                        pvm_pkg::OP_MUSIC_PLAY: active_next[0] = !(loop_enable && length == '0);
                        pvm_pkg::OP_MUSIC_STOP: active_next[0] = 1'b0;
                        pvm_pkg::OP_FX_PLAY:    active_next[slot] = 1'b1;
                        pvm_pkg::OP_FX_STOP:    active_next = {{EFFECT_VOICES{1'b0}}, active_reg[0]};
                        default:                state_next = S_DONE;
                    endcase
                end
            end
            S_VREAD:
            begin
                if (cur_active) begin
                    state_next = S_VEVAL;
                end else if (last_voice) begin
                    state_next = S_MUL;
                end else begin
                    idx_next = idx_reg + VW'(1);
                end
            end
            S_VEVAL:
            begin
                active_next[idx_reg] = go;
                if (go) begin
                    state_next = S_ACC;
                end else if (last_voice) begin
                    state_next = S_MUL;
                end else begin
                    idx_next   = idx_reg + VW'(1);
                    state_next = S_VREAD;
                end
            end
            S_ACC:
            begin
                sum_next = sum_reg + centered;
                if (last_voice) begin
                    state_next = S_MUL;
                end else begin
                    idx_next   = idx_reg + VW'(1);
                    state_next = S_VREAD;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (neg_reg) begin
                    res_sample_next = (quot > (PROD_W+1)'(128)) ? '0
                                    : pvm_pkg::SILENCE - quot[pvm_pkg::SAMPLE_W-1:0];
                end else begin
                    res_sample_next = (quot > (PROD_W+1)'(127)) ? pvm_pkg::SAMPLE_MAX
                                    : pvm_pkg::SILENCE + quot[pvm_pkg::SAMPLE_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            active_reg    <= '0;
            volume_reg    <= pvm_pkg::VOL_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
            if (cfg_write) begin
                volume_reg <= cfg_data;
            end
            if (state_reg == S_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        res_sample_reg <= res_sample_next;
        if (state_reg == S_MUL) begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(signed'({1'b0, volume_reg}));
        end
        if (state_reg == S_DIV) begin
            mag_reg <= mag;
            qe_reg  <= qe_calc;
            neg_reg <= prod_reg[PROD_W-1];
        end
        if (state_reg == S_DONE && out_free) begin
            sample_out_reg     <= res_sample_reg;
            music_playing_reg  <= active_reg[0];
            effects_active_reg <= flags_ext[4:1];
        end
    end

    assign out_valid      = out_valid_reg;
    assign sample_out     = sample_out_reg;
    assign music_playing  = music_playing_reg;
    assign effects_active = effects_active_reg;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench of the PCM voice mixer: directed table, random requests, voice predictor.
`default_nettype none
module tb_top;
    import pvm_pkg::*;

    localparam op_t OP_SPARE_A = 3'd6;
    localparam op_t OP_SPARE_B = 3'd7;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  PHASES = 7;
    localparam int  PHASE_REQUESTS = 72;
    localparam int  HOLD_CYCLES = 300;

    typedef struct packed {
        op_t          op;
        logic [15:0]  addr;
        logic [16:0]  len;
        logic         loop_en;
        sample_t      data;
    } mix_req_t;

    typedef struct packed {
        sample_t      sample;
        logic         music;
        logic [3:0]   fx;
    } mix_result_t;

    typedef struct packed {
        mix_req_t     req;
        logic         typed;
        mix_result_t  res;
    } step_row_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [VOL_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     operation = '0;
    logic [IN_ADDR_W-1:0] address = '0;
    logic [POS_W-1:0]    length = '0;
    logic                loop_enable = 1'b0;
    logic [SAMPLE_W-1:0] sample_byte = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SAMPLE_W-1:0] sample_out;
    logic                music_playing;
    logic [FLAGS_W-1:0]  effects_active;

    pcm_voice_mixer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .address        (address),
        .length         (length),
        .loop_enable    (loop_enable),
        .sample_byte    (sample_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample_out     (sample_out),
        .music_playing  (music_playing),
        .effects_active (effects_active)
    );

    // voice and memory image
    sample_t     mem_img [65536];
    bit          mem_loaded [65536];
    bit [7:0]    volume = 8'd255;
    bit [15:0]   mus_start;
    bit [16:0]   mus_len;
    bit [16:0]   mus_pos;
    bit          mus_loop;
    bit          mus_on;
    bit [15:0]   fx_start [4];
    bit [16:0]   fx_len [4];
    bit [16:0]   fx_pos [4];
    bit          fx_on [4];

    mix_result_t pending_results [$];
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          requests_sent = 0;
    int          work_requests = 0;
    int          ticks_sent = 0;
    int          loads_sent = 0;
    int          volume_changes = 0;
    int          cycle_count = 0;
    int          tx_pct = 0;
    int          rx_pct = 0;
    bit          hold_off_go = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
    end

    function automatic int fetch_centered(bit [15:0] base, bit [16:0] ofs);
        bit [15:0] a;
        int s;
        a = base + ofs[15:0];
        s = mem_img[a];
        return s - 128;
    endfunction

    function automatic mix_result_t predict_mix(mix_req_t r);
        mix_result_t res;
        int acc;
        int slot;
        bit found;
        res.sample = SILENCE;
        case (r.op)
            OP_TICK:
            begin
                acc = 0;
                if (mus_on)
                begin
                    if (mus_loop && mus_len == 0)
                        mus_on = 1'b0;
                    else if (mus_pos >= mus_len)
                    begin
                        if (mus_loop)
                            mus_pos = '0;
                        else
                            mus_on = 1'b0;
                    end
                    if (mus_on)
                    begin
                        acc += fetch_centered(mus_start, mus_pos);
                        mus_pos = mus_pos + 17'd1;
                    end
                end
                for (int v = 0; v < 4; v++)
                begin
                    if (fx_on[v])
                    begin
                        if (fx_pos[v] >= fx_len[v])
                            fx_on[v] = 1'b0;
                        else
                        begin
                            acc += fetch_centered(fx_start[v], fx_pos[v]);
                            fx_pos[v] = fx_pos[v] + 17'd1;
                        end
                    end
                end
                acc = (acc * int'(volume)) / 255;
                if (acc < -128)
                    acc = -128;
                if (acc > 127)
                    acc = 127;
                res.sample = sample_t'(acc + 128);
            end
            OP_MUSIC_PLAY:
            begin
                mus_start = r.addr;
                mus_len = r.len;
                mus_pos = '0;
                mus_loop = r.loop_en;
                mus_on = !(r.loop_en && r.len == 0);
            end
            OP_MUSIC_STOP:
                mus_on = 1'b0;
            OP_FX_PLAY:
            begin
                slot = 0;
                found = 1'b0;
                for (int v = 0; v < 4; v++)
                begin
                    if (!fx_on[v] && !found)
                    begin
                        slot = v;
                        found = 1'b1;
                    end
                end
                fx_start[slot] = r.addr;
                fx_len[slot] = r.len;
                fx_pos[slot] = '0;
                fx_on[slot] = 1'b1;
            end
            OP_FX_STOP:
                for (int v = 0; v < 4; v++)
                    fx_on[v] = 1'b0;
            OP_LOAD:
            begin
                mem_img[r.addr] = r.data;
                mem_loaded[r.addr] = 1'b1;
            end
            default:
                ;
        endcase
        res.music = mus_on;
        for (int v = 0; v < 4; v++)
            res.fx[v] = fx_on[v];
        return res;
    endfunction

    function automatic step_row_t step_row(op_t op, logic [15:0] addr, logic [16:0] len,
                                           logic loop_en, sample_t data, logic typed,
                                           sample_t smp, logic mus, logic [3:0] fx);
        step_row_t row;
        row.req = '{op: op, addr: addr, len: len, loop_en: loop_en, data: data};
        row.typed = typed;
        row.res = '{sample: smp, music: mus, fx: fx};
        return row;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch on %s at result %0d: got %0d, expected %0d",
                     what, results_checked, got, want);
    endtask

    // Hold the request until accepted, then predict its result.
    task automatic send_request(mix_req_t r, logic typed, mix_result_t typed_res);
        mix_result_t want;
        in_valid <= 1'b1;
        operation <= r.op;
        address <= r.addr;
        length <= r.len;
        loop_enable <= r.loop_en;
        sample_byte <= r.data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = predict_mix(r);
        if (typed)
            want = typed_res;
        pending_results.push_back(want);
        requests_sent++;
        if (r.op != OP_SPARE_A && r.op != OP_SPARE_B)
            work_requests++;
        if (r.op == OP_TICK)
            ticks_sent++;
        if (r.op == OP_LOAD)
            loads_sent++;
    endtask

    task automatic idle_gap();
        if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Load every byte the next tick will read that has never been written.
    task automatic load_pending_reads();
        logic [15:0] need [$];
        mix_req_t ld;
        if (mus_on && !(mus_loop && mus_len == 0))
        begin
            if (mus_pos < mus_len)
                need.push_back(mus_start + mus_pos[15:0]);
            else if (mus_loop)
                need.push_back(mus_start);
        end
        for (int v = 0; v < 4; v++)
            if (fx_on[v] && fx_pos[v] < fx_len[v])
                need.push_back(fx_start[v] + fx_pos[v][15:0]);
        foreach (need[i])
        begin
            if (!mem_loaded[need[i]])
            begin
                ld.op = OP_LOAD;
                ld.addr = need[i];
                ld.len = 17'($urandom);
                ld.loop_en = 1'($urandom);
                ld.data = 8'($urandom);
                send_request(ld, 1'b0, '0);
                idle_gap();
            end
        end
    endtask

    task automatic make_random(output mix_req_t r);
        int pick;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       r.addr = 16'hFFF8 + 16'($urandom_range(0, 7));
            1:       r.addr = 16'h0100 + 16'($urandom_range(0, 63));
            default: r.addr = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       r.len = '0;
            1:       r.len = 17'($urandom_range(13, 400));
            2:       r.len = 17'($urandom);
            default: r.len = 17'($urandom_range(1, 12));
        endcase
        r.loop_en = 1'($urandom);
        if ($urandom_range(0, 7) == 0)
            r.data = $urandom_range(0, 1) ? SAMPLE_MAX : 8'h00;
        else
            r.data = 8'($urandom);
        if (pick < 45)
            r.op = OP_TICK;
        else if (pick < 60)
            r.op = OP_FX_PLAY;
        else if (pick < 70)
            r.op = OP_MUSIC_PLAY;
        else if (pick < 85)
            r.op = OP_LOAD;
        else if (pick < 90)
            r.op = OP_MUSIC_STOP;
        else if (pick < 95)
            r.op = OP_FX_STOP;
        else
            r.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    endtask

    // Drain all pending results, then write the volume.
    task automatic set_volume(logic [7:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        volume = v;
        volume_changes++;
    endtask

    initial
    begin : rx_side
        int held;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_off_go)
            begin
                out_stall <= 1'b1;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                out_stall <= 1'b0;
                hold_off_go = 1'b0;
            end
            else if (rx_pct > 0 && $urandom_range(0, 99) < rx_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        mix_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request pending", sample_out, 0);
            else
            begin
                want = pending_results.pop_front();
                if (sample_out !== want.sample)
                    report_mismatch("sample_out", sample_out, want.sample);
                if (music_playing !== want.music)
                    report_mismatch("music_playing", music_playing, want.music);
                if (effects_active !== want.fx)
                    report_mismatch("effects_active", effects_active, want.fx);
                results_checked++;
            end
        end
    end

    initial
    begin : main_seq
        step_row_t directed [24];
        logic [7:0] phase_volume [PHASES];
        mix_req_t r;
        int base;

        directed = '{
            step_row(OP_TICK,       16'h0000, 17'h0,     1'b0, 8'h00, 1'b1, SILENCE,    1'b0, 4'h0),
            step_row(OP_LOAD,       16'hFFFF, 17'h0,     1'b0, 8'hFF, 1'b1, SILENCE,    1'b0, 4'h0),
            step_row(OP_LOAD,       16'h0000, 17'h0,     1'b0, 8'h00, 1'b1, SILENCE,    1'b0, 4'h0),
            step_row(OP_LOAD,       16'h0001, 17'h0,     1'b0, 8'h80, 1'b1, SILENCE,    1'b0, 4'h0),
            step_row(OP_SPARE_A,    16'h1234, 17'h1FFFF, 1'b1, 8'hAA, 1'b1, SILENCE,    1'b0, 4'h0),
            step_row(OP_SPARE_B,    16'hFFFF, 17'h1FFFF, 1'b1, 8'hFF, 1'b1, SILENCE,    1'b0, 4'h0),
            step_row(OP_MUSIC_PLAY, 16'hFFFF, 17'h2,     1'b1, 8'h00, 1'b1, SILENCE,    1'b1, 4'h0),
            step_row(OP_TICK,       16'h0000, 17'h0,     1'b0, 8'h00, 1'b1, SAMPLE_MAX, 1'b1, 4'h0),
            step_row(OP_TICK,       16'h0000, 17'h0,     1'b0, 8'h00, 1'b1, 8'h00,      1'b1, 4'h0),
            step_row(OP_TICK,       16'h0000, 17'h0,     1'b0, 8'h00, 1'b1, SAMPLE_MAX, 1'b1, 4'h0),
            step_row(OP_MUSIC_PLAY, 16'h0000, 17'h0,     1'b1, 8'h00, 1'b1, SILENCE,    1'b0, 4'h0),
            step_row(OP_MUSIC_PLAY, 16'h0000, 17'h0,     1'b0, 8'h00, 1'b1, SILENCE,    1'b1, 4'h0),
            step_row(OP_TICK,       16'h0000, 17'h0,     1'b0, 8'h00, 1'b1, SILENCE,    1'b0, 4'h0),
            step_row(OP_FX_PLAY,    16'h0000, 17'h1,     1'b0, 8'h00, 1'b1, SILENCE,    1'b0, 4'h1),
            step_row(OP_FX_PLAY,    16'hFFFF, 17'h1FFFF, 1'b0, 8'h00, 1'b1, SILENCE,    1'b0, 4'h3),
            step_row(OP_FX_PLAY,    16'h0001, 17'h0,     1'b0, 8'h00, 1'b1, SILENCE,    1'b0, 4'h7),
            step_row(OP_FX_PLAY,    16'hFFFF, 17'h1,     1'b0, 8'h00, 1'b1, SILENCE,    1'b0, 4'hF),
            step_row(OP_FX_PLAY,    16'h0001, 17'h1,     1'b0, 8'h00, 1'b1, SILENCE,    1'b0, 4'hF),
            step_row(OP_TICK,       16'h0000, 17'h0,     1'b0, 8'h00, 1'b0, SILENCE,    1'b0, 4'h0),
            step_row(OP_TICK,       16'h0000, 17'h0,     1'b0, 8'h00, 1'b0, SILENCE,    1'b0, 4'h0),
            step_row(OP_TICK,       16'h0000, 17'h0,     1'b0, 8'h00, 1'b0, SILENCE,    1'b0, 4'h0),
            step_row(OP_MUSIC_PLAY, 16'h0001, 17'h1,     1'b0, 8'h00, 1'b1, SILENCE,    1'b1, 4'h2),
            step_row(OP_MUSIC_STOP, 16'h0000, 17'h0,     1'b0, 8'h00, 1'b1, SILENCE,    1'b0, 4'h2),
            step_row(OP_FX_STOP,    16'h0000, 17'h0,     1'b0, 8'h00, 1'b1, SILENCE,    1'b0, 4'h0)
        };
        phase_volume[0] = 8'd0;
        phase_volume[1] = 8'd1;
        phase_volume[2] = 8'd128;
        phase_volume[3] = 8'd255;
        phase_volume[4] = 8'($urandom_range(2, 253));
        phase_volume[5] = 8'($urandom_range(2, 253));
        phase_volume[6] = 8'd254;

        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        tx_pct = 20;
        rx_pct = 20;
        foreach (directed[i])
        begin
            send_request(directed[i].req, directed[i].typed, directed[i].res);
            idle_gap();
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_volume(phase_volume[phase]);
            tx_pct = (phase == 1 || phase == 3 || phase == PHASES - 1) ? 0 : 30;
            rx_pct = tx_pct;
            if (phase == 2)
                hold_off_go = 1'b1;
            base = work_requests;
            while (work_requests - base < PHASE_REQUESTS)
            begin
                make_random(r);
                if (r.op == OP_TICK)
                    load_pending_reads();
                send_request(r, 1'b0, '0);
                idle_gap();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d requests: %0d ticks, %0d sample loads, %0d volume settings",
                 requests_sent, ticks_sent, loads_sent, volume_changes);
        $display("checked %0d results, including one long output hold-off", results_checked);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
